[design/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, item types and helpers of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned BitmapWords = 2048;
  localparam int unsigned WordBits    = 32;
  localparam int unsigned BitAw       = $clog2(WordBits);
  localparam int unsigned BlockW      = 16;

  // block numbers are 16 bits wide, so only this many words can be reached
  localparam int unsigned MaxReach   = (2 ** BlockW) / WordBits;
  localparam int unsigned ReachWords = (BitmapWords < MaxReach) ? BitmapWords : MaxReach;
  localparam int unsigned WordAw     = (ReachWords > 1) ? $clog2(ReachWords) : 1;

  // one summary bit per bitmap word, set while that word has a free block
  localparam int unsigned SumWords    = (ReachWords + WordBits - 1) / WordBits;
  localparam int unsigned SumAw       = (SumWords > 1) ? $clog2(SumWords) : 1;
  localparam int unsigned LastSumBits = ReachWords % WordBits;

  localparam logic [WordBits-1:0] AllFree  = 32'hFFFF_FFFF;
  localparam logic [WordBits-1:0] OneBit   = 32'h0000_0001;

  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StNotOpen = 2'd1,
    StNoFree  = 2'd2,
    StRange   = 2'd3
  } status_e;

  typedef struct packed {
    logic              mode;
    logic [BlockW-1:0] block_number;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [BlockW-1:0] allocated_block;
  } out_item_t;

  typedef struct packed {
    logic                bm_we;
    logic [WordAw-1:0]   bm_waddr;
    logic [WordBits-1:0] bm_wdata;
    logic [WordAw-1:0]   bm_raddr;
    logic                sm_we;
    logic [SumAw-1:0]    sm_waddr;
    logic [WordBits-1:0] sm_wdata;
    logic [SumAw-1:0]    sm_raddr;
  } mem_req_t;

  function automatic logic [BitAw-1:0] lsb32(input logic [WordBits-1:0] w);
    logic [BitAw-1:0] r;
    r = '0;
    for (int k = WordBits - 1; k >= 0; k--) begin
      if (w[k]) r = BitAw'(k);
    end
    return r;
  endfunction

  // summary word after reset: bits past the last reachable word stay clear
  function automatic logic [WordBits-1:0] sum_init(input logic [SumAw-1:0] j);
    logic [WordBits-1:0] r;
    r = AllFree;
    if ((LastSumBits != 0) && (32'(j) == SumWords - 1)) begin
      r = (OneBit << LastSumBits) - OneBit;
    end
    return r;
  endfunction

endpackage

[design/bba_ram.sv]
// ----------------------------------------------------------------------------
// bba_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/bba_core.sv]
// ----------------------------------------------------------------------------
// bba_core
// Request sequencer: walks summary and bitmap memories, read-modify-write.
// ----------------------------------------------------------------------------
module bba_core import bba_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fs_open_i,
  input  logic                clr_busy_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output mem_req_t            mem_o,
  input  logic [WordBits-1:0] bm_rdata_i,
  input  logic [WordBits-1:0] sm_rdata_i,
  input  logic                out_free_i,
  output logic                res_push_o,
  output out_item_t           res_o
);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SSum  = 3'd1;
  localparam logic [2:0] SWord = 3'd2;
  localparam logic [2:0] SFree = 3'd3;
  localparam logic [2:0] SResp = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [SumWords-1:0] top_q, top_d;
  logic [SumAw-1:0]    j_q, j_d;
  logic [BitAw-1:0]    i_q, i_d;
  logic [BitAw-1:0]    b_q, b_d;
  logic [WordAw-1:0]   w_q, w_d;
  logic [WordBits-1:0] sdata_q, sdata_d;
  out_item_t           res_q, res_d;

  logic                top_any;
  logic [SumAw-1:0]    top_j;
  logic                accept;
  logic [BitAw-1:0]    bit_sel;
  logic [WordBits-1:0] new_word;
  logic [WordBits-1:0] new_sum;

  // lowest word group that still has a free block
  always_comb begin
    top_j = '0;
    for (int k = SumWords - 1; k >= 0; k--) begin
      if (top_q[k]) top_j = SumAw'(k);
    end
  end

  assign top_any    = |top_q;
  assign in_ready_o = (state_q == SIdle) && !clr_busy_i;
  assign accept     = in_valid_i && in_ready_o;
  assign bit_sel    = lsb32(bm_rdata_i);
  assign new_word   = bm_rdata_i & ~(OneBit << bit_sel);
  assign new_sum    = sdata_q & ~(OneBit << i_q);

  always_comb begin
    state_d = state_q;
    top_d   = top_q;
    j_d     = j_q;
    i_d     = i_q;
    b_d     = b_q;
    w_d     = w_q;
    sdata_d = sdata_q;
    res_d   = res_q;
    mem_o   = '0;
    case (state_q)
      SIdle: begin
        if (accept) begin
          if (!fs_open_i) begin
            res_d   = '{status: StNotOpen, allocated_block: '0};
            state_d = SResp;
          end else if (in_data_i.mode == ModeAlloc) begin
            if (!top_any) begin
              res_d   = '{status: StNoFree, allocated_block: '0};
              state_d = SResp;
            end else begin
              j_d            = top_j;
              mem_o.sm_raddr = top_j;
              state_d        = SSum;
            end
          end else if (32'(in_data_i.block_number[15:5]) >= ReachWords) begin
            res_d   = '{status: StRange, allocated_block: '0};
            state_d = SResp;
          end else begin
            w_d            = WordAw'(in_data_i.block_number[15:5]);
            j_d            = SumAw'(in_data_i.block_number[15:10]);
            i_d            = in_data_i.block_number[9:5];
            b_d            = in_data_i.block_number[4:0];
            mem_o.bm_raddr = w_d;
            mem_o.sm_raddr = j_d;
            state_d        = SFree;
          end
        end
      end
      SSum: begin
        i_d            = lsb32(sm_rdata_i);
        sdata_d        = sm_rdata_i;
        w_d            = WordAw'({j_q, i_d});
        mem_o.bm_raddr = w_d;
        state_d        = SWord;
      end
      SWord: begin
        mem_o.bm_we    = 1'b1;
        mem_o.bm_waddr = w_q;
        mem_o.bm_wdata = new_word;
        // word now full: drop its summary bit, and the group bit if that empties too
        if (new_word == '0) begin
          mem_o.sm_we    = 1'b1;
          mem_o.sm_waddr = j_q;
          mem_o.sm_wdata = new_sum;
          if (new_sum == '0) top_d[j_q] = 1'b0;
        end
        res_d   = '{status: StOk, allocated_block: BlockW'({w_q, bit_sel})};
        state_d = SResp;
      end
      SFree: begin
        mem_o.bm_we    = 1'b1;
        mem_o.bm_waddr = w_q;
        mem_o.bm_wdata = bm_rdata_i | (OneBit << b_q);
        mem_o.sm_we    = 1'b1;
        mem_o.sm_waddr = j_q;
        mem_o.sm_wdata = sm_rdata_i | (OneBit << i_q);
        top_d[j_q]     = 1'b1;
        res_d          = '{status: StOk, allocated_block: '0};
        state_d        = SResp;
      end
      SResp: begin
        if (out_free_i) state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  assign res_push_o = (state_q == SResp) && out_free_i;
  assign res_o      = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      top_q   <= '1;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q     <= j_d;
    i_q     <= i_d;
    b_q     <= b_d;
    w_q     <= w_d;
    sdata_q <= sdata_d;
    res_q   <= res_d;
  end

endmodule

[design/bitmap_block_allocator_unit.sv]
// ----------------------------------------------------------------------------
// bitmap_block_allocator_unit
// First-fit free-block allocator over a bitmap held in on-chip RAM.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o/in_data_i) carries one request item:
// mode 0 allocates the lowest free block, mode 1 frees block_number. Every
// item gives exactly one result item on out_valid_o/out_ready_i/out_data_o.
// The cfg channel writes fs_open; it is always ready. It must be written only
// while no item is in flight; the block itself does not enforce this.
// A free reads the bitmap and summary words, writes both back, then loads
// the output register. An allocate reads the summary word picked from the
// group flags, then the bitmap word, writes back, then loads the output
// register. Items that fail early (not open, no free block, out of range)
// go straight to loading the output register. Requests are served one at
// a time; the next item is accepted the cycle after the previous result is
// loaded. After reset a sweep writes the bitmap RAM to all free, one word a
// cycle, over all 2048 words; the summary RAM is filled in the same sweep and
// in_ready_o stays low until it is done. A stalled receiver holds the result
// in the output register; the sequencer then waits with the next result.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_unit import bba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic                fs_open_q;
  logic                clr_busy_q;
  logic [WordAw-1:0]   clr_cnt_q;
  logic                out_valid_q;
  out_item_t           out_q;

  mem_req_t            req;
  logic [WordBits-1:0] bm_rdata, sm_rdata;
  logic                bm_we, sm_we;
  logic [WordAw-1:0]   bm_waddr;
  logic [SumAw-1:0]    sm_waddr;
  logic [WordBits-1:0] bm_wdata, sm_wdata;
  logic                out_free;
  logic                res_push;
  out_item_t           res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_open_q <= 1'b0;
    end else if (cfg_valid_i) begin
      fs_open_q <= cfg_data_i;
    end
  end

  // clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == WordAw'(ReachWords - 1)) clr_busy_q <= 1'b0;
    end
  end

  assign bm_we    = clr_busy_q | req.bm_we;
  assign bm_waddr = clr_busy_q ? clr_cnt_q : req.bm_waddr;
  assign bm_wdata = clr_busy_q ? AllFree : req.bm_wdata;
  assign sm_we    = clr_busy_q ? (32'(clr_cnt_q) < SumWords) : req.sm_we;
  assign sm_waddr = clr_busy_q ? SumAw'(clr_cnt_q) : req.sm_waddr;
  assign sm_wdata = clr_busy_q ? sum_init(SumAw'(clr_cnt_q)) : req.sm_wdata;

  bba_ram #(
    .Width(WordBits),
    .Depth(ReachWords)
  ) u_bitmap_ram (
    .clk_i  (clk_i),
    .we_i   (bm_we),
    .waddr_i(bm_waddr),
    .wdata_i(bm_wdata),
    .raddr_i(req.bm_raddr),
    .rdata_o(bm_rdata)
  );

  bba_ram #(
    .Width(WordBits),
    .Depth(SumWords)
  ) u_summary_ram (
    .clk_i  (clk_i),
    .we_i   (sm_we),
    .waddr_i(sm_waddr),
    .wdata_i(sm_wdata),
    .raddr_i(req.sm_raddr),
    .rdata_o(sm_rdata)
  );

  bba_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fs_open_i (fs_open_q),
    .clr_busy_i(clr_busy_q),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .mem_o     (req),
    .bm_rdata_i(bm_rdata),
    .sm_rdata_i(sm_rdata),
    .out_free_i(out_free),
    .res_push_o(res_push),
    .res_o     (res)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !clr_busy_q)
    else $error("item accepted during clearing sweep");

  a_no_core_write_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !req.bm_we && !req.sm_we)
    else $error("sequencer wrote memory during clearing sweep");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result overwritten");

  a_fail_zero_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != StOk) |-> out_data_o.allocated_block == '0)
    else $error("failed request returned a block number");

endmodule

[test/tb_bitmap_block_allocator_unit.sv]
// ----------------------------------------------------------------------------
// tb_bitmap_block_allocator_unit
// Self-checking bench for the first-fit bitmap block allocator. A scoreboard
// keeps its own free map and open flag and predicts every answer. A directed
// pass covers the closed state, block-number extremes, double frees and
// first-fit reuse. Random passes follow under several idle/stall mixes and a
// long output hold-off. A short final pass mixes frees and allocates with
// both sides idling, then checks the closed state once more.
// ----------------------------------------------------------------------------
module tb_bitmap_block_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  class alloc_scoreboard;
    logic [WordBits-1:0]   free_map [ReachWords];
    int unsigned           first_hint;
    logic                  is_open;
    out_item_t             expected_answers [$];
    logic [BlockW-1:0]     held [$];
    int unsigned           errors;

    function new();
      foreach (free_map[i]) free_map[i] = AllFree;
      first_hint   = 0;
      is_open      = 1'b0;
      errors       = 0;
    endfunction

    function void set_open(logic v);
      is_open = v;
    endfunction

    function int unsigned pending();
      return expected_answers.size();
    endfunction

    function void note_request(in_item_t req);
      out_item_t   ans;
      int unsigned w;
      int unsigned b;
      ans.status          = StOk;
      ans.allocated_block = '0;
      if (!is_open) begin
        ans.status = StNotOpen;
      end else if (req.mode == ModeAlloc) begin
        // words below the hint are known to be fully taken
        for (w = first_hint; w < ReachWords; w++) begin
          if (free_map[w] != '0) break;
        end
        first_hint = w;
        if (w == ReachWords) begin
          ans.status = StNoFree;
        end else begin
          for (b = 0; b < WordBits; b++) begin
            if (free_map[w][b]) break;
          end
          free_map[w][b]      = 1'b0;
          ans.allocated_block = BlockW'(w * WordBits + b);
          held.push_back(ans.allocated_block);
        end
      end else begin
        w = req.block_number / WordBits;
        if (w >= ReachWords) begin
          ans.status = StRange;
        end else begin
          free_map[w][req.block_number % WordBits] = 1'b1;
          if (w < first_hint) first_hint = w;
        end
      end
      expected_answers.push_back(ans);
    endfunction

    task report(string msg);
      if (errors < 100) $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_answer(out_item_t got);
      out_item_t want;
      if (expected_answers.size() == 0) begin
        report($sformatf("result with nothing expected: status %0d block %0d",
                         got.status, got.allocated_block));
        return;
      end
      want = expected_answers.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.allocated_block !== want.allocated_block)
        report($sformatf("allocated_block %0d, expected %0d",
                         got.allocated_block, want.allocated_block));
    endtask
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_data_i  = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  alloc_scoreboard sb;
  int unsigned     send_idle_pct  = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     hold_left      = 0;
  int unsigned     send_idle_mix [4] = '{0, 70, 0, 29};
  int unsigned     recv_stall_mix [4] = '{0, 0, 70, 29};

  bitmap_block_allocator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_open(cfg_data_i);
      if (in_valid_i && in_ready_o) sb.note_request(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_answer(out_data_o);
    end
  end

  function automatic in_item_t make_request(logic mode, logic [BlockW-1:0] blk);
    in_item_t r;
    r.mode         = mode;
    r.block_number = blk;
    return r;
  endfunction

  // half allocates; frees mostly return blocks handed out earlier
  function automatic in_item_t random_request();
    in_item_t    r;
    int unsigned pick;
    int unsigned k;
    r.mode         = ModeAlloc;
    r.block_number = BlockW'($urandom());
    pick = $urandom_range(99);
    if (pick >= 50) begin
      r.mode = ModeFree;
      if (pick < 88 && sb.held.size() != 0) begin
        k = $urandom_range(sb.held.size() - 1);
        r.block_number = sb.held[k];
        sb.held[k]     = sb.held[$];
        void'(sb.held.pop_back());
      end
    end
    return r;
  endfunction

  // returns at the edge where the item is accepted, valid still high
  task automatic push_item(in_item_t it);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_open(logic v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int p;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // closed after reset: everything answers not open
    push_item(make_request(ModeAlloc, 16'h0000));
    push_item(make_request(ModeFree, 16'hFFFF));
    settle();
    write_open(1'b1);

    push_item(make_request(ModeAlloc, 16'h0000));
    push_item(make_request(ModeAlloc, 16'hFFFF));
    push_item(make_request(ModeAlloc, 16'h1234));
    push_item(make_request(ModeFree, 16'h0001));
    push_item(make_request(ModeAlloc, 16'h0000));
    push_item(make_request(ModeAlloc, 16'h0000));
    push_item(make_request(ModeFree, 16'h0000));
    push_item(make_request(ModeFree, 16'h0000));  // already free
    push_item(make_request(ModeAlloc, 16'hAAAA));
    push_item(make_request(ModeFree, 16'hFFFF));  // top block, already free
    push_item(make_request(ModeFree, 16'h0000));
    push_item(make_request(ModeFree, 16'hAAAA));
    push_item(make_request(ModeFree, 16'h5555));
    push_item(make_request(ModeAlloc, 16'h5555));
    push_item(make_request(ModeAlloc, 16'h0000));
    push_item(make_request(ModeFree, 16'h001F));
    push_item(make_request(ModeFree, 16'h0020));
    push_item(make_request(ModeAlloc, 16'h0000));
    settle();

    for (p = 0; p < 4; p++) begin
      send_idle_pct  = send_idle_mix[p];
      recv_stall_pct = recv_stall_mix[p];
      write_open(1'b1);
      // long output hold-off so the input side backs up
      if (p == 0) hold_left = 300;
      repeat (370) push_item(random_request());
      settle();
      write_open(1'b0);
      repeat (20) push_item(random_request());
      settle();
    end

    // short mixed pass with both sides idling
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    write_open(1'b1);
    repeat (30) push_item(random_request());
    settle();
    write_open(1'b0);
    repeat (10) push_item(random_request());
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
design/bba_pkg.sv
design/bba_ram.sv
design/bba_core.sv
design/bitmap_block_allocator_unit.sv
test/tb_bitmap_block_allocator_unit.sv
